FILE: hw/rtl/skf_pkg.sv
// Shared types, widths and microprogram ROM for the multichannel scalar Kalman filter.
// No dependencies; used by skf_useq, skf_dpath and the top level.
`default_nettype none

package skf_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int NOISE_W  = 23;
  localparam int VAR_W    = 15;
  localparam int P_W      = 23;
  localparam int DEN_W    = 24;
  localparam int GAIN_W   = 17;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 3;
  localparam int CNT_W    = 4;
  localparam int MUL_A_W  = 18;
  localparam int MUL_B_W  = 24;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  // Saturation limit of the predicted variance (32767.0 with 8 fraction bits)
  localparam logic [P_W-1:0]    P_MAX     = 23'h7FFF00;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;
  localparam logic [CNT_W-1:0]  DIV_ITERS = 4'd15;
  localparam logic [NOISE_W-1:0] NOISE_RST = 23'd256;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PROCESS_NOISE     = 1'b0,
    CFG_MEASUREMENT_NOISE = 1'b1
  } cfg_reg_t;

  // Datapath operations, one per microprogram step
  typedef enum logic [2:0] {
    OP_WAIT = 3'd0,
    OP_LOAD = 3'd1,
    OP_DEN  = 3'd2,
    OP_DIV0 = 3'd3,
    OP_DIVI = 3'd4,
    OP_MUL1 = 3'd5,
    OP_MUL2 = 3'd6,
    OP_WRB  = 3'd7
  } op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_NONE     = 2'd0,
    JC_IN_WAIT  = 2'd1,
    JC_LOOP     = 2'd2,
    JC_OUT_BUSY = 2'd3
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Sequencer inputs from the datapath and the handshake logic
  typedef struct packed {
    logic in_fire;
    logic loop_more;
    logic out_busy;
  } seq_status_t;

  // Datapath control
  typedef struct packed {
    op_t  op;
    logic take;
    logic wr;
  } dp_ctrl_t;

  // Microprogram: eight steps, the last falls through to step 0
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    case (step)
      3'd0:    uw = '{op: OP_WAIT, cond: JC_IN_WAIT,  target: 3'd0};
      3'd1:    uw = '{op: OP_LOAD, cond: JC_NONE,     target: 3'd0};
      3'd2:    uw = '{op: OP_DEN,  cond: JC_NONE,     target: 3'd0};
      3'd3:    uw = '{op: OP_DIV0, cond: JC_NONE,     target: 3'd0};
      3'd4:    uw = '{op: OP_DIVI, cond: JC_LOOP,     target: 3'd4};
      3'd5:    uw = '{op: OP_MUL1, cond: JC_NONE,     target: 3'd0};
      3'd6:    uw = '{op: OP_MUL2, cond: JC_NONE,     target: 3'd0};
      3'd7:    uw = '{op: OP_WRB,  cond: JC_OUT_BUSY, target: 3'd7};
      default: uw = '{op: OP_WAIT, cond: JC_IN_WAIT,  target: 3'd0};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/skf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module skf_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/skf_useq.sv
// Microprogram sequencer: step counter, control ROM and conditional jumps.
// Depends on skf_pkg.
`default_nettype none

module skf_useq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire skf_pkg::seq_status_t status,
  output skf_pkg::op_t              op
);

  logic [skf_pkg::STEP_W-1:0] pc_r, pc_nxt;
  skf_pkg::ucode_t            uw;
  logic                       jump;

  assign uw = skf_pkg::ucode_rom(pc_r);
  assign op = uw.op;

  // Evaluate the jump condition of the current step
  always_comb begin
    case (uw.cond)
      skf_pkg::JC_NONE:     jump = 1'b0;
      skf_pkg::JC_IN_WAIT:  jump = !status.in_fire;
      skf_pkg::JC_LOOP:     jump = status.loop_more;
      skf_pkg::JC_OUT_BUSY: jump = status.out_busy;
      default:              jump = 1'b0;
    endcase
    pc_nxt = jump ? uw.target : pc_r + 1'b1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/skf_dpath.sv
// Datapath: variance prediction, restoring gain divider, shared multiplier, update.
// Depends on skf_pkg.
`default_nettype none

module skf_dpath (
  input  wire logic                                 clk,
  input  wire skf_pkg::dp_ctrl_t                    ctrl,
  input  wire logic signed [skf_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic signed [skf_pkg::SAMPLE_W-1:0]  st_est,
  input  wire logic        [skf_pkg::VAR_W-1:0]     st_var,
  input  wire logic        [skf_pkg::NOISE_W-1:0]   q_noise,
  input  wire logic        [skf_pkg::NOISE_W-1:0]   r_noise,
  output logic                                      loop_more,
  output logic signed [skf_pkg::SAMPLE_W-1:0]       new_est,
  output logic        [skf_pkg::VAR_W-1:0]          new_var
);

  localparam int SW = skf_pkg::SAMPLE_W;
  localparam int AW = skf_pkg::MUL_A_W;
  localparam int BW = skf_pkg::MUL_B_W;
  localparam int PW = skf_pkg::PROD_W;

  logic signed [SW-1:0]               sample_r;
  logic signed [SW-1:0]               est_r;
  logic        [skf_pkg::P_W-1:0]     p_r;
  logic        [skf_pkg::DEN_W-1:0]   den_r;
  logic        [skf_pkg::DEN_W-1:0]   rem_r;
  logic        [skf_pkg::GAIN_W-1:0]  q_r;
  logic        [skf_pkg::CNT_W-1:0]   cnt_r;
  logic signed [PW-1:0]               prod_r;
  logic signed [SW-1:0]               new_est_r;

  logic        [skf_pkg::DEN_W-1:0]   p_sum;
  logic        [skf_pkg::P_W-1:0]     p_sat;
  logic        [skf_pkg::DEN_W:0]     rem_sh;
  logic                               q_bit;
  logic        [skf_pkg::GAIN_W-1:0]  gain;
  logic signed [SW:0]                 diff;
  logic signed [AW-1:0]               mul_a;
  logic signed [BW-1:0]               mul_b;
  logic signed [PW-1:0]               mul_p;
  logic signed [PW-1:0]               num;
  logic signed [PW-1:0]               num_rnd;

  // Predicted variance with 8 fraction bits, saturated
  assign p_sum = {1'b0, st_var, 8'h00} + {1'b0, q_noise};
  assign p_sat = (p_sum > {1'b0, skf_pkg::P_MAX}) ? skf_pkg::P_MAX
                                                   : p_sum[skf_pkg::P_W-1:0];

  // One restoring division step
  assign rem_sh = {rem_r, 1'b0};
  assign q_bit  = rem_sh >= {1'b0, den_r};

  // Zero denominator forces zero gain
  assign gain = (den_r == '0) ? '0 : q_r;
  assign diff = (SW+1)'(sample_r) - (SW+1)'(est_r);

  // Shared multiplier operand select
  always_comb begin
    if (ctrl.op == skf_pkg::OP_MUL1) begin
      mul_a = {1'b0, gain};
      mul_b = BW'(diff);
    end else begin
      mul_a = {1'b0, skf_pkg::GAIN_ONE - gain};
      mul_b = {1'b0, p_r};
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Estimate update, truncated toward zero
  assign num     = (PW'(est_r) <<< skf_pkg::FRAC_W) + prod_r;
  assign num_rnd = num + (num[PW-1] ? PW'(65535) : PW'(0));

  assign loop_more = cnt_r != '0;
  assign new_est   = new_est_r;
  assign new_var   = prod_r[skf_pkg::VAR_W+23:24];

  // Step the datapath registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      skf_pkg::OP_WAIT: begin
        if (ctrl.take) begin
          sample_r <= in_sample;
        end
      end
      skf_pkg::OP_LOAD: begin
        est_r <= st_est;
        p_r   <= p_sat;
      end
      skf_pkg::OP_DEN: begin
        den_r <= {1'b0, p_r} + {1'b0, r_noise};
      end
      skf_pkg::OP_DIV0: begin
        cnt_r <= skf_pkg::DIV_ITERS;
        if ({1'b0, p_r} >= den_r) begin
          rem_r <= {1'b0, p_r} - den_r;
          q_r   <= skf_pkg::GAIN_W'(1);
        end else begin
          rem_r <= {1'b0, p_r};
          q_r   <= '0;
        end
      end
      skf_pkg::OP_DIVI: begin
        cnt_r <= cnt_r - 1'b1;
        q_r   <= {q_r[skf_pkg::GAIN_W-2:0], q_bit};
        if (q_bit) begin
          rem_r <= skf_pkg::DEN_W'(rem_sh - {1'b0, den_r});
        end else begin
          rem_r <= rem_sh[skf_pkg::DEN_W-1:0];
        end
      end
      skf_pkg::OP_MUL1: begin
        prod_r <= mul_p;
      end
      skf_pkg::OP_MUL2: begin
        new_est_r <= num_rnd[SW+skf_pkg::FRAC_W-1:skf_pkg::FRAC_W];
        prod_r    <= mul_p;
      end
      skf_pkg::OP_WRB: begin
        // Hold; the top level takes the results
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scalar_kalman_filter_multichannel_top.sv
// Top level of the multichannel scalar Kalman filter: handshakes, configuration,
// channel state RAM. Depends on skf_pkg, skf_ram, skf_useq and skf_dpath.
//
//   channel  direction  ports                                  handshake
//   in       input      in_sample, in_channel                  in_valid / in_ready
//   out      output     out_estimate                           out_valid / out_ready
//   cfg      input      cfg_index, cfg_wdata                   cfg_wr_en (no wait)
//
// Each item runs through a microprogram of eight steps, of which the gain divider
// step repeats once for each quotient bit but the first (one quotient bit per cycle).
// Reset clears the step counter, the channel valid bits and the output valid flag,
// and loads both noise registers with 1.0. A result that is not taken holds
// the write-back step; the next item can be accepted as soon as it is written to the
// output register.
`default_nettype none

module scalar_kalman_filter_multichannel_top #(
  parameter int CHANNELS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [skf_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic        [2:0]                     in_channel,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [skf_pkg::SAMPLE_W-1:0]        out_estimate,
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [0:0]                     cfg_index,
  input  wire logic        [skf_pkg::NOISE_W-1:0]    cfg_wdata
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ST_W  = skf_pkg::SAMPLE_W + skf_pkg::VAR_W;
  localparam int SW    = skf_pkg::SAMPLE_W;

  logic [skf_pkg::NOISE_W-1:0] q_noise_r;
  logic [skf_pkg::NOISE_W-1:0] r_noise_r;
  logic [CHANNELS-1:0]         vld_r;
  logic [CH_W-1:0]             ch_r;
  logic                        hit_r;
  logic                        out_valid_r;
  logic signed [SW-1:0]        out_est_r;

  skf_pkg::op_t        op;
  skf_pkg::seq_status_t status;
  skf_pkg::dp_ctrl_t   ctrl;
  logic                in_fire;
  logic                out_busy;
  logic                loop_more;
  logic [CH_W-1:0]     ch_idx;
  logic [ST_W-1:0]     rd_data;
  logic signed [SW-1:0] st_est;
  logic [skf_pkg::VAR_W-1:0] st_var;
  logic signed [SW-1:0] new_est;
  logic [skf_pkg::VAR_W-1:0] new_var;

  // Reduce a channel number modulo CHANNELS by repeated subtraction
  function automatic logic [CH_W-1:0] ch_map(input logic [2:0] ch);
    logic [6:0] v;
    v = {4'b0, ch};
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(CHANNELS)) begin
        v = v - 7'(CHANNELS);
      end
    end
    return v[CH_W-1:0];
  endfunction

  assign ch_idx   = ch_map(in_channel);
  assign in_ready = (op == skf_pkg::OP_WAIT);
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid_r && !out_ready;

  assign status = '{in_fire: in_fire, loop_more: loop_more, out_busy: out_busy};
  assign ctrl   = '{op: op, take: in_fire,
                    wr: (op == skf_pkg::OP_WRB) && !out_busy};

  // Channel state, unwritten channels read as zero
  assign st_est = hit_r ? rd_data[ST_W-1:skf_pkg::VAR_W] : '0;
  assign st_var = hit_r ? rd_data[skf_pkg::VAR_W-1:0] : '0;

  skf_ram #(
    .WIDTH (ST_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (ctrl.wr),
    .wr_addr (ch_r),
    .wr_data ({new_est, new_var}),
    .rd_en   (in_fire),
    .rd_addr (ch_idx),
    .rd_data (rd_data)
  );

  skf_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  skf_dpath u_dpath (
    .clk       (clk),
    .ctrl      (ctrl),
    .in_sample (in_sample),
    .st_est    (st_est),
    .st_var    (st_var),
    .q_noise   (q_noise_r),
    .r_noise   (r_noise_r),
    .loop_more (loop_more),
    .new_est   (new_est),
    .new_var   (new_var)
  );

  // Latch the channel and its valid bit at acceptance
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r  <= ch_idx;
      hit_r <= vld_r[ch_idx];
    end
  end

  // Mark written channels valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.wr) begin
      vld_r[ch_r] <= 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_noise_r <= skf_pkg::NOISE_RST;
      r_noise_r <= skf_pkg::NOISE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        skf_pkg::CFG_PROCESS_NOISE:     q_noise_r <= cfg_wdata;
        skf_pkg::CFG_MEASUREMENT_NOISE: r_noise_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Output register: load on write-back, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      out_est_r <= new_est;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;

endmodule

`default_nettype wire
